### rtl/mpr_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// mpr_pkg
// Shared constants, types and the CRC-16/CCITT-FALSE byte update for the
// multidrop packet receiver.
// ============================================================================
package mpr_pkg;

  // Payload store depth in bytes (16 to 256).
  localparam int PAYLOAD_DEPTH = 256;
  localparam int PAY_AW        = $clog2(PAYLOAD_DEPTH);

  // Depth as a 9-bit value for compares against frame counters.
  localparam logic [8:0] PAYLOAD_DEPTH_W = 9'(PAYLOAD_DEPTH);

  // Address, length and two CRC bytes around the payload.
  localparam logic [8:0] FRAME_OVERHEAD = 9'd4;
  localparam logic [8:0] CRC_BYTES      = 9'd2;
  localparam logic [8:0] POS_AFTER_ADDR = 9'd1;
  localparam logic [8:0] POS_AFTER_LEN  = 9'd2;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  // Configuration register byte addresses.
  localparam logic [1:0] ADDR_NODE_ADDRESS = 2'd0;

  // Status that goes out with every result word.
  typedef struct packed {
    logic       receiving;
    logic       ready;
    logic       error;
    logic [7:0] length;
  } status_t;

  // Payload store write request.
  typedef struct packed {
    logic              en;
    logic [PAY_AW-1:0] addr;
    logic [7:0]        data;
  } wr_req_t;

  // One byte of CRC-16/CCITT-FALSE (poly 0x1021, MSB first).
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0] x;
    x = crc[15:8] ^ b;
    x = x ^ {4'h0, x[7:4]};
    return {crc[7:0], 8'h00} ^ {x[3:0], 12'h000} ^ {3'b000, x, 5'b00000} ^ {8'h00, x};
  endfunction

endpackage

### rtl/multidrop_packet_receiver.sv
`timescale 1ns / 1ps
// ============================================================================
// multidrop_packet_receiver
// Nine-bit multidrop UART packet receiver with CRC-16/CCITT-FALSE check and a
// payload store that can be read back word by word.
// ============================================================================
// Usage:
// Each input word is either a received line word (in_mode = 0: in_addr_flag
// and in_line_byte) or a payload read (in_mode = 1: in_read_index). Every
// input word produces exactly one result word carrying the status after the
// update (out_receiving, out_packet_ready, out_packet_error,
// out_payload_length) and, for reads, the stored payload byte.
// Throughput is one word per cycle while the output is not stalled; the
// result and the payload store read are both registered at the accept edge.
// The output register is a single stage: while it holds a word and
// out_stall is high, in_stall is raised and no new word is taken; otherwise
// a word is accepted every cycle, including the cycle in which the held
// result leaves. The payload store read port is enabled only on accepted
// reads, so a stalled read result holds its data.
// Reset clears the frame state and the status flags at once. The payload
// store is not cleared and needs no clearing pass: reads are gated by the
// ready flag and the held length, so an unwritten entry is never shown.
// The node address is set through the APB-style port at byte address 0.
// ============================================================================
module multidrop_packet_receiver (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic        in_addr_flag,
  input  logic [7:0]  in_line_byte,
  input  logic [7:0]  in_read_index,
  // Result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_receiving,
  output logic        out_packet_ready,
  output logic        out_packet_error,
  output logic [7:0]  out_payload_length,
  output logic [7:0]  out_read_data,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic             in_accept;
  logic             out_take;
  logic [7:0]       node_address;
  mpr_pkg::status_t status_cur;
  mpr_pkg::status_t status_nxt;
  mpr_pkg::wr_req_t wr_req;
  logic             rd_ok;
  logic             rd_en;
  logic [7:0]       ram_rdata;

  logic             out_valid_r,  out_valid_nxt;
  mpr_pkg::status_t out_status_r;
  logic             rd_ok_r;

  // The output register is full and stalled: hold the input side.
  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign out_take  = out_valid_r && !out_stall;

  mpr_cfg_regs u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .node_address (node_address)
  );

  mpr_frame_ctrl u_frame (
    .clk          (clk),
    .rst_n        (rst_n),
    .word_en      (in_accept && !in_mode),
    .addr_flag    (in_addr_flag),
    .line_byte    (in_line_byte),
    .node_address (node_address),
    .status_cur   (status_cur),
    .status_nxt   (status_nxt),
    .wr_req       (wr_req)
  );

  // A read returns data only for a ready packet and an index inside it.
  assign rd_ok = status_cur.ready && (in_read_index < status_cur.length) &&
                 ({1'b0, in_read_index} < mpr_pkg::PAYLOAD_DEPTH_W);
  assign rd_en = in_accept && in_mode;

  mpr_ram #(
    .WIDTH (8),
    .DEPTH (mpr_pkg::PAYLOAD_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (wr_req.en),
    .waddr (wr_req.addr),
    .wdata (wr_req.data),
    .re    (rd_en),
    .raddr (in_read_index[mpr_pkg::PAY_AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload: loaded only on accept, so it holds while stalled.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_status_r <= status_nxt;
      rd_ok_r      <= rd_en && rd_ok;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_receiving      = out_status_r.receiving;
  assign out_packet_ready   = out_status_r.ready;
  assign out_packet_error   = out_status_r.error;
  assign out_payload_length = out_status_r.length;
  assign out_read_data      = rd_ok_r ? ram_rdata : 8'h00;

endmodule

### rtl/mpr_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// mpr_ram
// Generic single-write, single-read synchronous RAM with a registered read.
// ============================================================================
module mpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/mpr_cfg_regs.sv
`timescale 1ns / 1ps
// ============================================================================
// mpr_cfg_regs
// APB-style register file holding the node address.
// ============================================================================
module mpr_cfg_regs (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [7:0]  node_address
);

  logic [7:0] node_addr_r;
  logic [7:0] node_addr_nxt;

  always_comb begin
    node_addr_nxt = node_addr_r;
    if (psel && penable && pwrite && (paddr == mpr_pkg::ADDR_NODE_ADDRESS)) begin
      node_addr_nxt = pwdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_addr_r <= 8'h00;
    end else begin
      node_addr_r <= node_addr_nxt;
    end
  end

  assign prdata       = (paddr == mpr_pkg::ADDR_NODE_ADDRESS) ? {24'h000000, node_addr_r}
                                                              : 32'h00000000;
  assign pready       = 1'b1;
  assign node_address = node_addr_r;

endmodule

### rtl/mpr_frame_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// mpr_frame_ctrl
// Frame sequencer: address match, length, payload store writes, running CRC
// and the end-of-frame check.
// ============================================================================
module mpr_frame_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              word_en,
  input  logic              addr_flag,
  input  logic [7:0]        line_byte,
  input  logic [7:0]        node_address,
  output mpr_pkg::status_t  status_cur,
  output mpr_pkg::status_t  status_nxt,
  output mpr_pkg::wr_req_t  wr_req
);

  logic        in_packet_r,  in_packet_nxt;
  logic        len_pend_r,   len_pend_nxt;
  logic [8:0]  byte_pos_r,   byte_pos_nxt;
  logic [8:0]  frame_size_r, frame_size_nxt;
  logic [15:0] crc_r,        crc_nxt;
  logic [15:0] rx_crc_r,     rx_crc_nxt;
  logic        ready_r,      ready_nxt;
  logic        error_r,      error_nxt;
  logic [7:0]  held_len_r,   held_len_nxt;

  logic [8:0]  crc_pos;
  logic [8:0]  store_idx;
  logic [8:0]  frame_len;
  logic [15:0] rx_crc_full;

  assign crc_pos     = frame_size_r - mpr_pkg::CRC_BYTES;
  assign store_idx   = byte_pos_r - mpr_pkg::POS_AFTER_LEN;
  assign frame_len   = frame_size_r - mpr_pkg::FRAME_OVERHEAD;
  assign rx_crc_full = rx_crc_r | {8'h00, line_byte};

  always_comb begin
    in_packet_nxt  = in_packet_r;
    len_pend_nxt   = len_pend_r;
    byte_pos_nxt   = byte_pos_r;
    frame_size_nxt = frame_size_r;
    crc_nxt        = crc_r;
    rx_crc_nxt     = rx_crc_r;
    ready_nxt      = ready_r;
    error_nxt      = error_r;
    held_len_nxt   = held_len_r;
    wr_req.en      = 1'b0;
    wr_req.addr    = store_idx[mpr_pkg::PAY_AW-1:0];
    wr_req.data    = line_byte;

    if (word_en) begin
      if (addr_flag && (line_byte == node_address)) begin
        // Own address starts (or restarts) a frame and clears the status.
        in_packet_nxt  = 1'b1;
        len_pend_nxt   = 1'b1;
        byte_pos_nxt   = mpr_pkg::POS_AFTER_ADDR;
        frame_size_nxt = 9'd0;
        crc_nxt        = mpr_pkg::crc_byte(mpr_pkg::CRC_INIT, line_byte);
        rx_crc_nxt     = 16'h0000;
        ready_nxt      = 1'b0;
        error_nxt      = 1'b0;
        held_len_nxt   = 8'h00;
      end else if (in_packet_r) begin
        if (len_pend_r) begin
          frame_size_nxt = {1'b0, line_byte} + mpr_pkg::FRAME_OVERHEAD;
          len_pend_nxt   = 1'b0;
          crc_nxt        = mpr_pkg::crc_byte(crc_r, line_byte);
          byte_pos_nxt   = mpr_pkg::POS_AFTER_LEN;
        end else begin
          byte_pos_nxt = byte_pos_r + 9'd1;
          if (byte_pos_r < crc_pos) begin
            // Payload byte: stored while it fits, always hashed.
            wr_req.en = (store_idx < mpr_pkg::PAYLOAD_DEPTH_W);
            crc_nxt   = mpr_pkg::crc_byte(crc_r, line_byte);
          end else if (byte_pos_r == crc_pos) begin
            rx_crc_nxt = {line_byte, 8'h00};
          end else begin
            rx_crc_nxt    = rx_crc_full;
            in_packet_nxt = 1'b0;
            if ((rx_crc_full == crc_r) && (frame_len <= mpr_pkg::PAYLOAD_DEPTH_W)) begin
              ready_nxt    = 1'b1;
              error_nxt    = 1'b0;
              held_len_nxt = frame_len[7:0];
            end else begin
              ready_nxt    = 1'b0;
              error_nxt    = 1'b1;
              held_len_nxt = 8'h00;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_packet_r  <= 1'b0;
      len_pend_r   <= 1'b0;
      byte_pos_r   <= 9'd0;
      frame_size_r <= 9'd0;
      crc_r        <= mpr_pkg::CRC_INIT;
      rx_crc_r     <= 16'h0000;
      ready_r      <= 1'b0;
      error_r      <= 1'b0;
      held_len_r   <= 8'h00;
    end else begin
      in_packet_r  <= in_packet_nxt;
      len_pend_r   <= len_pend_nxt;
      byte_pos_r   <= byte_pos_nxt;
      frame_size_r <= frame_size_nxt;
      crc_r        <= crc_nxt;
      rx_crc_r     <= rx_crc_nxt;
      ready_r      <= ready_nxt;
      error_r      <= error_nxt;
      held_len_r   <= held_len_nxt;
    end
  end

  assign status_cur.receiving = in_packet_r;
  assign status_cur.ready     = ready_r;
  assign status_cur.error     = error_r;
  assign status_cur.length    = ready_r ? held_len_r : 8'h00;

  assign status_nxt.receiving = in_packet_nxt;
  assign status_nxt.ready     = ready_nxt;
  assign status_nxt.error     = error_nxt;
  assign status_nxt.length    = ready_nxt ? held_len_nxt : 8'h00;

endmodule

### rtl/mpr_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// mpr_checker
// Port-level checks on the result channel of the packet receiver.
// ============================================================================
module mpr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_receiving,
  input logic       out_packet_ready,
  input logic       out_packet_error,
  input logic [7:0] out_payload_length,
  input logic [7:0] out_read_data
);

  // A stalled result word stays and keeps its payload.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_payload_length) &&
    $stable(out_read_data) && $stable(out_packet_ready))
    else $error("stalled result word changed");

  // Without a ready packet there is no length and no read data.
  a_no_ready_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_packet_ready |-> out_payload_length == 8'h00 &&
    out_read_data == 8'h00)
    else $error("length or data shown without a ready packet");

  // Ready and error never stand together.
  a_ready_xor_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_packet_ready && out_packet_error))
    else $error("ready and error both set");

  // A frame being collected means the previous status was cleared.
  a_recv_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_receiving |-> !out_packet_ready && !out_packet_error)
    else $error("status not cleared while receiving");

endmodule

bind multidrop_packet_receiver mpr_checker u_mpr_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_receiving      (out_receiving),
  .out_packet_ready   (out_packet_ready),
  .out_packet_error   (out_packet_error),
  .out_payload_length (out_payload_length),
  .out_read_data      (out_read_data)
);

### sim/tb_multidrop_packet_receiver.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_multidrop_packet_receiver
// Self-checking testbench for the nine-bit multidrop packet receiver. A
// clocked driver feeds line and read words from a pending queue, a clocked
// monitor checks every result word against a status prediction worked out
// at the moment each input word is accepted, and both sides idle and stall
// at random. The node address is rewritten through the APB-style port
// between phases, while the block is idle.
// ============================================================================
module tb_multidrop_packet_receiver;

  // Input word modes.
  localparam logic MODE_LINE = 1'b0;
  localparam logic MODE_READ = 1'b1;

  // Frame layout: address, length, payload, CRC high, CRC low.
  localparam logic [8:0]  FRAME_EXTRA   = 9'd4;
  localparam logic [8:0]  CRC_TAIL      = 9'd2;
  localparam logic [8:0]  POS_FIRST_LEN = 9'd1;
  localparam logic [8:0]  POS_FIRST_PAY = 9'd2;
  localparam logic [15:0] CRC_POLY      = 16'h1021;

  localparam int PHASES         = 5;
  localparam int PHASE_ITEMS    = 390;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int REPORT_LIMIT   = 10;
  // Room a long frame needs in the phase budget before one is queued.
  localparam int LONG_ROOM      = 260;

  typedef struct packed {
    logic       mode;
    logic       addr_flag;
    logic [7:0] line_byte;
    logic [7:0] read_index;
  } rx_word_t;

  typedef struct packed {
    logic       receiving;
    logic       ready;
    logic       error;
    logic [7:0] length;
    logic [7:0] read_data;
  } status_word_t;

  typedef enum {PKT_GOOD, PKT_BAD_CRC, PKT_CUT} packet_kind_t;

  // --------------------------------------------------------------------------
  // Clock, reset and the block's inputs. Every input has a known value from
  // time zero; the clock starts low so the first edge is a clean rise.
  // --------------------------------------------------------------------------
  logic clk;
  logic rst_n = 1'b0;

  logic     in_valid = 1'b0;
  logic     in_stall;
  rx_word_t cur_word = '0;
  logic     in_mode;
  logic     in_addr_flag;
  logic [7:0] in_line_byte;
  logic [7:0] in_read_index;

  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_receiving;
  logic       out_packet_ready;
  logic       out_packet_error;
  logic [7:0] out_payload_length;
  logic [7:0] out_read_data;

  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [1:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  // The payload ports follow the word register that the driver updates.
  assign in_mode       = cur_word.mode;
  assign in_addr_flag  = cur_word.addr_flag;
  assign in_line_byte  = cur_word.line_byte;
  assign in_read_index = cur_word.read_index;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  multidrop_packet_receiver i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_mode            (in_mode),
    .in_addr_flag       (in_addr_flag),
    .in_line_byte       (in_line_byte),
    .in_read_index      (in_read_index),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_receiving      (out_receiving),
    .out_packet_ready   (out_packet_ready),
    .out_packet_error   (out_packet_error),
    .out_payload_length (out_payload_length),
    .out_read_data      (out_read_data),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  // --------------------------------------------------------------------------
  // Receiver state as the testbench sees it. The store is not initialised,
  // but the read gating means an entry is only ever shown after this packet
  // wrote it, so the initial contents never matter.
  // --------------------------------------------------------------------------
  logic [7:0]  rx_node        = 8'h00;
  logic        rx_in_packet   = 1'b0;
  logic        rx_len_pending = 1'b0;
  logic [8:0]  rx_pos         = '0;
  logic [8:0]  rx_frame       = '0;
  logic [15:0] rx_crc         = mpr_pkg::CRC_INIT;
  logic [15:0] rx_crc_field   = '0;
  logic [7:0]  rx_store [mpr_pkg::PAYLOAD_DEPTH];
  logic        rx_ready       = 1'b0;
  logic        rx_error       = 1'b0;
  logic [7:0]  rx_held        = '0;

  rx_word_t     pending_words [$];
  status_word_t status_due [$];

  int  in_gap          = 0;
  int  stall_left      = 0;
  bit  no_idle         = 1'b0;
  int  idle_cycles     = 0;
  int  words_accepted  = 0;
  int  results_checked = 0;
  int  bad_results     = 0;
  int  frames_good     = 0;
  int  frames_bad_crc  = 0;
  int  frames_cut      = 0;

  // CRC-16/CCITT-FALSE, one byte, worked bit by bit from the polynomial.
  function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++)
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    return c;
  endfunction

  // Advance the receiver state by one accepted word and return the status
  // that the block must report for it.
  task automatic receive_word(input rx_word_t w, output status_word_t r);
    logic [8:0] pos;
    logic [7:0] rd;
    int         slot;
    pos = rx_pos;
    rd  = 8'h00;
    if (w.mode == MODE_LINE) begin
      if (w.addr_flag && w.line_byte == rx_node) begin
        // Our own address always opens a fresh frame, even mid-packet.
        rx_in_packet   = 1'b1;
        rx_len_pending = 1'b1;
        rx_pos         = POS_FIRST_LEN;
        rx_frame       = '0;
        rx_crc         = crc16_update(mpr_pkg::CRC_INIT, w.line_byte);
        rx_crc_field   = '0;
        rx_ready       = 1'b0;
        rx_error       = 1'b0;
        rx_held        = '0;
      end else if (rx_in_packet) begin
        // Foreign address words land here too and count as plain data.
        if (rx_len_pending) begin
          rx_frame       = {1'b0, w.line_byte} + FRAME_EXTRA;
          rx_len_pending = 1'b0;
          rx_crc         = crc16_update(rx_crc, w.line_byte);
          rx_pos         = POS_FIRST_PAY;
        end else begin
          if (pos < rx_frame - CRC_TAIL) begin
            slot = int'(pos) - int'(POS_FIRST_PAY);
            if (slot < mpr_pkg::PAYLOAD_DEPTH)
              rx_store[slot] = w.line_byte;
            rx_crc = crc16_update(rx_crc, w.line_byte);
          end else if (pos == rx_frame - CRC_TAIL) begin
            rx_crc_field = {w.line_byte, 8'h00};
          end else begin
            rx_crc_field = rx_crc_field | {8'h00, w.line_byte};
            rx_in_packet = 1'b0;
            if (rx_crc_field == rx_crc &&
                int'(rx_frame - FRAME_EXTRA) <= mpr_pkg::PAYLOAD_DEPTH) begin
              rx_ready = 1'b1;
              rx_error = 1'b0;
              rx_held  = 8'(rx_frame - FRAME_EXTRA);
            end else begin
              rx_ready = 1'b0;
              rx_error = 1'b1;
              rx_held  = '0;
            end
          end
          rx_pos = pos + 9'd1;
        end
      end
    end else if (rx_ready && w.read_index < rx_held &&
                 int'(w.read_index) < mpr_pkg::PAYLOAD_DEPTH) begin
      rd = rx_store[w.read_index];
    end
    r.receiving = rx_in_packet;
    r.ready     = rx_ready;
    r.error     = rx_error;
    r.length    = rx_ready ? rx_held : 8'h00;
    r.read_data = rd;
  endtask

  // Gap or stall length: mostly none or short, now and then a long one.
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55)
      return 0;
    else if (r < 93)
      return $urandom_range(1, 3);
    else
      return $urandom_range(8, 40);
  endfunction

  // Address flag for a byte inside a frame: sometimes set, but never on a
  // byte equal to our address, which would restart the frame.
  function automatic logic foreign_flag(input logic [7:0] b, input logic [7:0] node);
    return (b != node) && ($urandom_range(0, 3) == 0);
  endfunction

  // Line words carry a random read index so that field toggles as well.
  function automatic void push_line(input logic flag, input logic [7:0] b);
    pending_words.push_back(rx_word_t'{MODE_LINE, flag, b, 8'($urandom)});
  endfunction

  function automatic void push_read(input logic [7:0] idx);
    pending_words.push_back(rx_word_t'{MODE_READ, 1'($urandom), 8'($urandom), idx});
  endfunction

  // Queue one frame for the given node. A cut frame stops after the given
  // payload bytes and never sends its CRC.
  task automatic queue_packet(input logic [7:0] node, input int len,
                              input logic [7:0] body[$], input packet_kind_t kind);
    logic [15:0] crc;
    crc = crc16_update(mpr_pkg::CRC_INIT, node);
    push_line(1'b1, node);
    crc = crc16_update(crc, 8'(len));
    push_line(foreign_flag(8'(len), node), 8'(len));
    foreach (body[i]) begin
      push_line(foreign_flag(body[i], node), body[i]);
      crc = crc16_update(crc, body[i]);
    end
    case (kind)
      PKT_CUT: begin
        frames_cut++;
      end
      PKT_BAD_CRC: begin
        crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
        frames_bad_crc++;
      end
      default: begin
        frames_good++;
      end
    endcase
    if (kind != PKT_CUT) begin
      push_line(foreign_flag(crc[15:8], node), crc[15:8]);
      push_line(foreign_flag(crc[7:0], node), crc[7:0]);
    end
  endtask

  // Random traffic for one phase: mostly complete frames with random
  // content, read bursts against the held packet, frames cut short so the
  // next address word restarts them, and some stray words. A long frame is
  // only queued while the budget still has room for it, so a phase ends
  // close to its word count.
  task automatic queue_random_traffic(input logic [7:0] node, input int budget);
    logic [7:0] body[$];
    int used;
    int start_size;
    int pick;
    int n;
    used = 0;
    while (used < budget) begin
      start_size = pending_words.size();
      pick       = $urandom_range(0, 99);
      body       = {};
      if (pick < 55) begin
        n = ($urandom_range(0, 99) < 3 && budget - used > LONG_ROOM) ?
            $urandom_range(200, 255) : $urandom_range(0, 12);
        repeat (n) body.push_back(8'($urandom));
        queue_packet(node, n, body, ($urandom_range(0, 5) == 0) ? PKT_BAD_CRC : PKT_GOOD);
      end else if (pick < 75) begin
        repeat ($urandom_range(1, 6))
          push_read(($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 15)) : 8'($urandom));
      end else if (pick < 87) begin
        n = $urandom_range(1, 12);
        repeat ($urandom_range(0, n - 1)) body.push_back(8'($urandom));
        queue_packet(node, n, body, PKT_CUT);
      end else begin
        repeat ($urandom_range(1, 4)) push_line(1'($urandom), 8'($urandom));
      end
      used += pending_words.size() - start_size;
    end
  endtask

  // One APB write of the node address: setup cycle, then access cycle. The
  // register takes the value at the edge that closes the access cycle.
  task automatic write_node_address(input logic [7:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= mpr_pkg::ADDR_NODE_ADDRESS;
    pwdata  <= {24'h000000, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    rx_node  = value;
  endtask

  // Wait until every queued word went in and every result came out, then
  // let the output register settle.
  task automatic wait_drained();
    while (pending_words.size() != 0 || in_valid || status_due.size() != 0)
      @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Driver. A word is taken at an edge with in_valid high and in_stall low;
  // its status is predicted right there. A stalled word is held unchanged,
  // and in_valid only moves when the slot is free, so it never follows the
  // stall and never gets two updates in one step.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive_p
    status_word_t due;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        receive_word(cur_word, due);
        status_due.push_back(due);
        words_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (in_gap != 0) begin
          in_valid <= 1'b0;
          in_gap   <= in_gap - 1;
        end else if (pending_words.size() != 0) begin
          cur_word <= pending_words.pop_front();
          in_valid <= 1'b1;
          in_gap   <= draw_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor. Each result word taken at an edge is compared field by field
  // with the oldest pending status. The stall pattern is drawn here too,
  // independent of out_valid, so stalls hit idle and busy cycles alike.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_p
    status_word_t got;
    status_word_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got.receiving = out_receiving;
        got.ready     = out_packet_ready;
        got.error     = out_packet_error;
        got.length    = out_payload_length;
        got.read_data = out_read_data;
        results_checked++;
        if (status_due.size() == 0) begin
          bad_results++;
          if (bad_results <= REPORT_LIMIT)
            $display("%0t: unexpected result: recv=%0b rdy=%0b err=%0b len=%0d data=%02h",
                     $time, got.receiving, got.ready, got.error, got.length, got.read_data);
        end else begin
          want = status_due.pop_front();
          if (got.receiving !== want.receiving || got.ready !== want.ready ||
              got.error !== want.error || got.length !== want.length ||
              got.read_data !== want.read_data) begin
            bad_results++;
            if (bad_results <= REPORT_LIMIT) begin
              $display("%0t: mismatch: expected recv=%0b rdy=%0b err=%0b len=%0d data=%02h",
                       $time, want.receiving, want.ready, want.error, want.length,
                       want.read_data);
              $display("    got recv=%0b rdy=%0b err=%0b len=%0d data=%02h",
                       got.receiving, got.ready, got.error, got.length, got.read_data);
            end
          end
        end
      end
      if (stall_left != 0) begin
        out_stall  <= 1'b1;
        stall_left <= stall_left - 1;
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
        out_stall  <= 1'b1;
        stall_left <= draw_gap();
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: too many cycles in a row with no handshake on any port means
  // the block hung.
  always @(posedge clk) begin
    if (!rst_n || psel || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
      $display("tb_multidrop_packet_receiver: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus. Reset once, a directed-then-random phase at node address zero,
  // then random phases at all-ones, two random addresses and address one.
  // The third phase runs without gaps or stalls to push back-to-back words.
  // --------------------------------------------------------------------------
  initial begin : stimulus_p
    logic [7:0] body[$];
    logic [7:0] node;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_node_address(8'h00);
    // Nothing is held yet, so a read shows zero.
    push_read(8'h00);
    // A data word and a foreign address word while idle are both dropped.
    push_line(1'b0, 8'hFF);
    push_line(1'b1, 8'h7E);
    // A good frame whose payload holds the byte extremes, then reads inside
    // the payload, right at its length and at the top index.
    body = {};
    body.push_back(8'hFF);
    body.push_back(8'h00);
    queue_packet(8'h00, 2, body, PKT_GOOD);
    push_read(8'h00);
    push_read(8'h02);
    push_read(8'hFF);
    // Zero length: the CRC follows the length byte directly.
    body = {};
    queue_packet(8'h00, 0, body, PKT_GOOD);
    queue_packet(8'h00, 0, body, PKT_BAD_CRC);
    // Own address inside an unfinished frame restarts it.
    queue_packet(8'h00, 2, body, PKT_CUT);
    body.push_back(8'h01);
    queue_packet(8'h00, 1, body, PKT_GOOD);
    push_read(8'h00);
    queue_random_traffic(8'h00, PHASE_ITEMS);
    wait_drained();

    for (int ph = 1; ph < PHASES; ph++) begin
      case (ph)
        1:       node = 8'hFF;
        4:       node = 8'h01;
        default: node = 8'($urandom);
      endcase
      write_node_address(node);
      no_idle = (ph == 2);
      queue_random_traffic(node, PHASE_ITEMS);
      wait_drained();
    end

    repeat (4) @(posedge clk);
    $display("Sent %0d words and checked %0d results across %0d node addresses.",
             words_accepted, results_checked, PHASES);
    $display("Frames: %0d well formed, %0d with a bad CRC, %0d cut short; %0d mismatches.",
             frames_good, frames_bad_crc, frames_cut, bad_results);
    if (bad_results == 0 && status_due.size() == 0) begin
      $display("tb_multidrop_packet_receiver: PASS");
    end else begin
      $display("tb_multidrop_packet_receiver: FAIL");
    end
    $finish;
  end

endmodule

### sim.f
rtl/mpr_pkg.sv
rtl/mpr_ram.sv
rtl/mpr_cfg_regs.sv
rtl/mpr_frame_ctrl.sv
rtl/multidrop_packet_receiver.sv
rtl/mpr_checker.sv
sim/tb_multidrop_packet_receiver.sv
